FILE: rtl/char_lcd_nibble_sequencer_core_macros.svh
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_CORE_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLNS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("CLNS assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("CLNS assertion failed");

`endif

FILE: rtl/clns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer package
// Types, codes and constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
package clns_pkg;

	localparam int COLUMN_COUNT = 40;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int TICK_W       = 16;

	localparam logic [5:0] COL_MAX = 6'(COLUMN_COUNT - 1);

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_CMD  = 2'd1,
		OP_DATA = 2'd2,
		OP_MOVE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_CMD  = 2'd1,
		KIND_DATA = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
	} item_t;

	typedef enum logic [2:0] {
		PH_PWRUP      = 3'd0,
		PH_NIB_HI     = 3'd1,
		PH_NIB_LO     = 3'd2,
		PH_INIT_WAIT  = 3'd3,
		PH_CLEAR_WAIT = 3'd4,
		PH_IDLE       = 3'd5
	} phase_t;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE_HIGH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_UP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_LONG   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_SHORT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_WAIT  = 3'd5;

	localparam logic [TICK_W-1:0] RST_ENABLE_HIGH = 16'd1000;
	localparam logic [TICK_W-1:0] RST_ENABLE_LOW  = 16'd1000;
	localparam logic [TICK_W-1:0] RST_POWER_UP    = 16'd20000;
	localparam logic [TICK_W-1:0] RST_INIT_LONG   = 16'd5000;
	localparam logic [TICK_W-1:0] RST_INIT_SHORT  = 16'd150;
	localparam logic [TICK_W-1:0] RST_CLEAR_WAIT  = 16'd2000;

	localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
	localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
	localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
	localparam logic [7:0] CMD_CLEAR        = 8'h01;
	localparam logic [7:0] ADDR_ROW0        = 8'h80;
	localparam logic [7:0] ADDR_ROW1        = 8'hC0;
	localparam logic [3:0] NIB_WAKE         = 4'h3;
	localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;

	localparam logic [3:0] IDX_FIRST_CMD = 4'd4;
	localparam logic [3:0] IDX_LAST_CMD  = 4'd7;
	localparam logic [3:0] IDX_DONE      = 4'd8;

	function automatic logic [7:0] init_cmd(input logic [1:0] sel);
		logic [7:0] cmd;
		case (sel)
			2'd0: cmd = CMD_FUNCTION_SET;
			2'd1: cmd = CMD_DISPLAY_ON;
			2'd2: cmd = CMD_ENTRY_MODE;
			default: cmd = CMD_CLEAR;
		endcase
		return cmd;
	endfunction

endpackage

FILE: rtl/char_lcd_nibble_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer core
// Power-up init and byte transfers to a character LCD on a 4-bit bus.
// ----------------------------------------------------------------------------
// Each transfer on the s_ channel is one item: a microsecond tick, a command
// byte, a data byte or a cursor move. Every item gives exactly one transfer
// on the m_ channel with the pin levels, the busy flag and whether a request
// was taken. Requests that arrive while init or a transfer runs are rejected.
// Timing registers are written over the cfg_ channel, which is always ready.
// Each item is registered in the two-entry queue and then in the result
// register that drives m_tdata. One item is taken every cycle while the
// receiver does not stall; the sequencer updates its state once per item.
// Reset loads the default timing values and starts the power-up wait.
// When the receiver stalls, the result register holds, the two-entry queue
// fills, and s_tready drops until the stall clears.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [15:0]                     s_tdata,   // byte_value, column, row
	input  logic [1:0]                      s_tuser,   // op
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [15:0]                     m_tdata,   // pin_rs, pin_rw, pin_en,
	                                                   // pin_nibble, busy_res, accepted
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [clns_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [clns_pkg::CFG_DATA_W-1:0] cfg_data
);
	import clns_pkg::*;

	logic  q_full;
	logic  q_push;
	item_t q_item;
	logic  q_pop;
	logic  q_not_empty;
	item_t q_head;

	clns_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.op         (s_tuser),
		.byte_value (s_tdata[7:0]),
		.column     (s_tdata[13:8]),
		.row        (s_tdata[14]),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (q_item)
	);

	clns_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	clns_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

FILE: rtl/clns_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer: front end
// Accepts input transfers and turns each into a tick or a byte to send.
// ----------------------------------------------------------------------------
module clns_front (
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [1:0]          op,
	input  logic [7:0]          byte_value,
	input  logic [5:0]          column,
	input  logic                row,
	input  logic                q_full,
	output logic                q_push,
	output clns_pkg::item_t     q_item
);
	import clns_pkg::*;

	logic [5:0] col_sat;
	logic [7:0] addr;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// Cursor moves become an address command with the column clamped to the display.
	assign col_sat = (column > COL_MAX) ? COL_MAX : column;
	assign addr    = (row ? ADDR_ROW1 : ADDR_ROW0) + {2'b00, col_sat};

	always_comb begin
		case (op_t'(op))
			OP_TICK: begin
				q_item.kind  = KIND_TICK;
				q_item.value = byte_value;
			end
			OP_CMD: begin
				q_item.kind  = KIND_CMD;
				q_item.value = byte_value;
			end
			OP_DATA: begin
				q_item.kind  = KIND_DATA;
				q_item.value = byte_value;
			end
			default: begin
				q_item.kind  = KIND_CMD;
				q_item.value = addr;
			end
		endcase
	end

endmodule

FILE: rtl/clns_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer: item queue
// Two-entry queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
module clns_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  clns_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output clns_pkg::item_t head
);
	import clns_pkg::*;

	item_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/clns_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer: back end
// Timing registers, init and transfer sequencer, and the result register.
// ----------------------------------------------------------------------------
module clns_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [clns_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [clns_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              q_not_empty,
	input  clns_pkg::item_t                   q_head,
	output logic                              q_pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata
);
	import clns_pkg::*;

	logic [TICK_W-1:0] en_high_q, en_low_q, pwr_wait_q, long_wait_q, short_wait_q, clr_wait_q;

	phase_t            phase_q, phase_d;
	logic [TICK_W-1:0] wait_q, wait_d;
	logic [3:0]        idx_q, idx_d, idx_inc;
	logic [7:0]        held_q, held_d;
	logic              second_q, second_d;
	logic              rs_q, rs_d;
	logic              en_q, en_d;
	logic [3:0]        nib_q, nib_d;
	logic              acc_d;
	logic              cfg_wr;
	logic              take;

	logic              res_valid_q;
	logic [15:0]       res_q;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid;
	assign take      = !res_valid_q || m_tready;
	assign q_pop     = q_not_empty && take;
	assign idx_inc   = idx_q + 4'd1;
	assign m_tvalid  = res_valid_q;
	assign m_tdata   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_high_q    <= RST_ENABLE_HIGH;
			en_low_q     <= RST_ENABLE_LOW;
			pwr_wait_q   <= RST_POWER_UP;
			long_wait_q  <= RST_INIT_LONG;
			short_wait_q <= RST_INIT_SHORT;
			clr_wait_q   <= RST_CLEAR_WAIT;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_ENABLE_HIGH: en_high_q    <= cfg_data;
				REG_ENABLE_LOW:  en_low_q     <= cfg_data;
				REG_POWER_UP:    pwr_wait_q   <= cfg_data;
				REG_INIT_LONG:   long_wait_q  <= cfg_data;
				REG_INIT_SHORT:  short_wait_q <= cfg_data;
				REG_CLEAR_WAIT:  clr_wait_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d  = phase_q;
		wait_d   = wait_q;
		idx_d    = idx_q;
		held_d   = held_q;
		second_d = second_q;
		rs_d     = rs_q;
		en_d     = en_q;
		nib_d    = nib_q;
		acc_d    = 1'b0;

		if (q_pop) begin
			if (q_head.kind == KIND_TICK) begin
				if (phase_q != PH_IDLE) begin
					if (wait_q > 16'd1) begin
						wait_d = wait_q - 16'd1;
					end else begin
						case (phase_q)
							PH_PWRUP: begin
								idx_d   = 4'd0;
								nib_d   = NIB_WAKE;
								en_d    = 1'b1;
								wait_d  = en_high_q;
								phase_d = PH_NIB_HI;
							end
							PH_NIB_HI: begin
								en_d    = 1'b0;
								wait_d  = en_low_q;
								phase_d = PH_NIB_LO;
							end
							PH_NIB_LO: begin
								if (idx_q < IDX_FIRST_CMD) begin
									if (idx_q == 4'd1) begin
										wait_d  = short_wait_q;
										phase_d = PH_INIT_WAIT;
									end else if (idx_q == 4'd3) begin
										idx_d    = IDX_FIRST_CMD;
										held_d   = CMD_FUNCTION_SET;
										rs_d     = 1'b0;
										second_d = 1'b0;
										nib_d    = CMD_FUNCTION_SET[7:4];
										en_d     = 1'b1;
										wait_d   = en_high_q;
										phase_d  = PH_NIB_HI;
									end else begin
										wait_d  = long_wait_q;
										phase_d = PH_INIT_WAIT;
									end
								end else if (!second_q) begin
									second_d = 1'b1;
									nib_d    = held_q[3:0];
									en_d     = 1'b1;
									wait_d   = en_high_q;
									phase_d  = PH_NIB_HI;
								end else if (idx_q < IDX_LAST_CMD) begin
									idx_d    = idx_inc;
									held_d   = init_cmd(idx_inc[1:0]);
									rs_d     = 1'b0;
									second_d = 1'b0;
									nib_d    = held_d[7:4];
									en_d     = 1'b1;
									wait_d   = en_high_q;
									phase_d  = PH_NIB_HI;
								end else if (idx_q == IDX_LAST_CMD) begin
									idx_d = IDX_DONE;
									if (clr_wait_q != 16'd0) begin
										wait_d  = clr_wait_q;
										phase_d = PH_CLEAR_WAIT;
									end else begin
										rs_d    = 1'b0;
										en_d    = 1'b0;
										phase_d = PH_IDLE;
									end
								end else begin
									rs_d    = 1'b0;
									en_d    = 1'b0;
									phase_d = PH_IDLE;
								end
							end
							PH_INIT_WAIT: begin
								idx_d   = {2'b00, idx_inc[1:0]};
								nib_d   = (idx_inc[1:0] == 2'd3) ? NIB_FOUR_BIT : NIB_WAKE;
								en_d    = 1'b1;
								wait_d  = en_high_q;
								phase_d = PH_NIB_HI;
							end
							default: begin
								rs_d    = 1'b0;
								en_d    = 1'b0;
								phase_d = PH_IDLE;
							end
						endcase
					end
				end
			end else if (phase_q == PH_IDLE) begin
				acc_d    = 1'b1;
				held_d   = q_head.value;
				rs_d     = (q_head.kind == KIND_DATA);
				second_d = 1'b0;
				nib_d    = q_head.value[7:4];
				en_d     = 1'b1;
				wait_d   = en_high_q;
				phase_d  = PH_NIB_HI;
			end
		end

		// A new power-up wait restarts the power-up wait while it runs.
		if (cfg_wr && cfg_index == REG_POWER_UP && phase_q == PH_PWRUP) begin
			wait_d = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PWRUP;
			wait_q   <= RST_POWER_UP;
			idx_q    <= 4'd0;
			held_q   <= 8'd0;
			second_q <= 1'b0;
			rs_q     <= 1'b0;
			en_q     <= 1'b0;
			nib_q    <= 4'd0;
		end else begin
			phase_q  <= phase_d;
			wait_q   <= wait_d;
			idx_q    <= idx_d;
			held_q   <= held_d;
			second_q <= second_d;
			rs_q     <= rs_d;
			en_q     <= en_d;
			nib_q    <= nib_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= {7'd0, acc_d, (phase_d != PH_IDLE), nib_d, en_d, 1'b0, rs_d};
		end
	end

endmodule

FILE: rtl/clns_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer: port checker
// Assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_sequencer_core_macros.svh"

module clns_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	`CLNS_ASSERT_NEXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`CLNS_ASSERT_NEXT(a_hold_data, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	`CLNS_ASSERT_IMPL(a_accept_busy, clk, arst_n, m_tvalid && m_tdata[8], m_tdata[7])
	`CLNS_ASSERT_IMPL(a_pins_busy, clk, arst_n, m_tvalid && (m_tdata[2] || m_tdata[0]), m_tdata[7] && !m_tdata[1])

endmodule

bind char_lcd_nibble_sequencer_core clns_checker u_clns_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: test/lcd_pin_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD pin checker
// Watches the item, result and register channels of the sequencer core,
// predicts the pin levels, busy flag and acceptance of every item, and
// compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module lcd_pin_checker import clns_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [15:0]           s_tdata,
	input  logic [1:0]            s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [15:0]           m_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    outstanding,
	output logic                  lcd_busy,
	output int                    checked_count,
	output int                    taken_count
);

	typedef struct packed {
		logic       rs;
		logic       rw;
		logic       en;
		logic [3:0] nibble;
		logic       busy;
		logic       taken;
	} pin_levels_t;

	logic [TICK_W-1:0] timing [0:5];
	phase_t            phase;
	logic [TICK_W-1:0] countdown;
	logic [3:0]        init_step;
	logic [7:0]        held;
	logic              low_half;
	logic              lcd_rs;
	logic              lcd_en;
	logic [3:0]        lcd_nibble;

	pin_levels_t pins_q [$];
	pin_levels_t want;
	pin_levels_t predicted;
	op_t         op_in;
	logic [5:0]  col_sat;
	logic        taken_now;
	int          mismatches = 0;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string what, input int got, input int want_v);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t: mismatch on %s, got %0d, expected %0d", $time, what, got, want_v);
	endtask

	task automatic load_nibble(input logic [3:0] v);
		lcd_nibble = v;
		lcd_en = 1'b1;
		countdown = timing[REG_ENABLE_HIGH];
		phase = PH_NIB_HI;
	endtask

	task automatic load_byte(input logic [7:0] b, input logic data_sel);
		held = b;
		lcd_rs = data_sel;
		low_half = 1'b0;
		load_nibble(b[7:4]);
	endtask

	task automatic go_idle();
		lcd_rs = 1'b0;
		lcd_en = 1'b0;
		phase = PH_IDLE;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing[REG_ENABLE_HIGH] = RST_ENABLE_HIGH;
			timing[REG_ENABLE_LOW] = RST_ENABLE_LOW;
			timing[REG_POWER_UP] = RST_POWER_UP;
			timing[REG_INIT_LONG] = RST_INIT_LONG;
			timing[REG_INIT_SHORT] = RST_INIT_SHORT;
			timing[REG_CLEAR_WAIT] = RST_CLEAR_WAIT;
			phase = PH_PWRUP;
			countdown = RST_POWER_UP;
			init_step = '0;
			held = '0;
			low_half = 1'b0;
			lcd_rs = 1'b0;
			lcd_en = 1'b0;
			lcd_nibble = '0;
			pins_q.delete();
			outstanding <= 0;
			lcd_busy <= 1'b1;
			checked_count <= 0;
			taken_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index <= REG_CLEAR_WAIT)
					timing[cfg_index] = cfg_data;
				if (cfg_index == REG_POWER_UP && phase == PH_PWRUP)
					countdown = cfg_data;
			end

			if (m_tvalid && m_tready) begin
				if (pins_q.size() == 0) begin
					report_mismatch("result transfer with none expected", 1, 0);
				end else begin
					want = pins_q.pop_front();
					checked_count <= checked_count + 1;
					if (m_tdata[0] !== want.rs)
						report_mismatch("pin_rs", m_tdata[0], want.rs);
					if (m_tdata[1] !== want.rw)
						report_mismatch("pin_rw", m_tdata[1], want.rw);
					if (m_tdata[2] !== want.en)
						report_mismatch("pin_en", m_tdata[2], want.en);
					if (m_tdata[6:3] !== want.nibble)
						report_mismatch("pin_nibble", m_tdata[6:3], want.nibble);
					if (m_tdata[7] !== want.busy)
						report_mismatch("busy_res", m_tdata[7], want.busy);
					if (m_tdata[8] !== want.taken)
						report_mismatch("accepted", m_tdata[8], want.taken);
				end
			end

			if (s_tvalid && s_tready) begin
				op_in = op_t'(s_tuser);
				taken_now = 1'b0;
				if (op_in == OP_TICK) begin
					if (phase != PH_IDLE) begin
						if (countdown > 16'd1) begin
							countdown = countdown - 16'd1;
						end else begin
							case (phase)
								PH_PWRUP: begin
									init_step = '0;
									load_nibble(NIB_WAKE);
								end
								PH_NIB_HI: begin
									lcd_en = 1'b0;
									countdown = timing[REG_ENABLE_LOW];
									phase = PH_NIB_LO;
								end
								PH_NIB_LO: begin
									if (init_step < IDX_FIRST_CMD) begin
										if (init_step == 4'd1) begin
											countdown = timing[REG_INIT_SHORT];
											phase = PH_INIT_WAIT;
										end else if (init_step == 4'd3) begin
											init_step = IDX_FIRST_CMD;
											load_byte(CMD_FUNCTION_SET, 1'b0);
										end else begin
											countdown = timing[REG_INIT_LONG];
											phase = PH_INIT_WAIT;
										end
									end else if (!low_half) begin
										low_half = 1'b1;
										load_nibble(held[3:0]);
									end else if (init_step < IDX_LAST_CMD) begin
										init_step = init_step + 4'd1;
										case (init_step)
											4'd5: load_byte(CMD_DISPLAY_ON, 1'b0);
											4'd6: load_byte(CMD_ENTRY_MODE, 1'b0);
											default: load_byte(CMD_CLEAR, 1'b0);
										endcase
									end else if (init_step == IDX_LAST_CMD) begin
										init_step = IDX_DONE;
										if (timing[REG_CLEAR_WAIT] != '0) begin
											countdown = timing[REG_CLEAR_WAIT];
											phase = PH_CLEAR_WAIT;
										end else begin
											go_idle();
										end
									end else begin
										go_idle();
									end
								end
								PH_INIT_WAIT: begin
									init_step = (init_step + 4'd1) & 4'd3;
									load_nibble(init_step == 4'd3 ? NIB_FOUR_BIT : NIB_WAKE);
								end
								default: go_idle();
							endcase
						end
					end
				end else if (phase == PH_IDLE) begin
					taken_now = 1'b1;
					case (op_in)
						OP_CMD: load_byte(s_tdata[7:0], 1'b0);
						OP_DATA: load_byte(s_tdata[7:0], 1'b1);
						default: begin
							col_sat = (s_tdata[13:8] > COL_MAX) ? COL_MAX : s_tdata[13:8];
							load_byte((s_tdata[14] ? ADDR_ROW1 : ADDR_ROW0) + {2'b00, col_sat},
								1'b0);
						end
					endcase
				end
				predicted.rs = lcd_rs;
				predicted.rw = 1'b0;
				predicted.en = lcd_en;
				predicted.nibble = lcd_nibble;
				predicted.busy = (phase != PH_IDLE);
				predicted.taken = taken_now;
				pins_q.push_back(predicted);
				if (taken_now)
					taken_count <= taken_count + 1;
			end

			outstanding <= pins_q.size();
			lcd_busy <= (phase != PH_IDLE);
		end
	end

endmodule

FILE: test/tb_char_lcd_nibble_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD nibble sequencer testbench
// Runs the power-up sequence, directed command, data and cursor transfers,
// extreme and zero timing settings, then random request and tick streams
// with random gaps and stalls on both channels, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_sequencer_core;
	import clns_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_LONG = 80;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [15:0]           s_tdata = '0;
	logic [1:0]            s_tuser = OP_TICK;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [15:0]           m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int   fail_count;
	int   outstanding;
	logic lcd_busy;
	int   checked_count;
	int   taken_count;

	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit hold_req = 1'b0;
	int hold_len = 0;
	int cycles = 0;
	int sent = 0;
	int p;

	always #1 clk = ~clk;

	char_lcd_nibble_sequencer_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lcd_pin_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.lcd_busy      (lcd_busy),
		.checked_count (checked_count),
		.taken_count   (taken_count)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
			end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_item(input op_t op, input logic [7:0] bv, input logic [5:0] col,
			input logic row);
		cfg_valid <= 1'b0;
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, row, col, bv};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic tick();
		send_item(OP_TICK, 8'($urandom), 6'($urandom), 1'($urandom));
	endtask

	task automatic tick_n(input int n);
		repeat (n) tick();
	endtask

	task automatic tick_until_idle();
		do tick(); while (lcd_busy);
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	function automatic logic [15:0] short_ticks();
		return ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
	endfunction

	task automatic random_request();
		logic [5:0] col;
		col = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(40, 63)) :
			6'($urandom_range(0, 39));
		send_item(op_t'($urandom_range(1, 3)), 8'($urandom), col, 1'($urandom));
	endtask

	task automatic random_phase(input int n_items);
		int start;
		start = sent;
		while (sent - start < n_items) begin
			if ($urandom_range(0, 3) != 0) begin
				random_request();
				tick_until_idle();
			end else begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 2) == 0)
						random_request();
					else
						tick();
				end
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A long power-up wait is cut short by rewriting it before it runs out.
		write_reg(REG_POWER_UP, 16'hFFFF);
		tick_n(3);
		send_item(OP_CMD, 8'h41, 6'd0, 1'b0);
		wait_for_results();
		write_reg(REG_ENABLE_HIGH, 16'd0);
		write_reg(REG_ENABLE_LOW, 16'd1);
		write_reg(REG_INIT_LONG, 16'd2);
		write_reg(REG_INIT_SHORT, 16'd0);
		write_reg(REG_CLEAR_WAIT, 16'd0);
		write_reg(REG_UNUSED_LO, 16'hFFFF);
		write_reg(REG_UNUSED_HI, 16'h1234);
		write_reg(REG_POWER_UP, 16'd4);
		tick_n(6);
		send_item(OP_DATA, 8'hFF, 6'd0, 1'b0);
		send_item(OP_MOVE, 8'h00, 6'd39, 1'b1);
		tick_until_idle();

		wait_for_results();
		write_reg(REG_ENABLE_HIGH, 16'd3);
		write_reg(REG_ENABLE_LOW, 16'd2);
		send_item(OP_CMD, 8'h00, 6'd0, 1'b0);
		tick_until_idle();
		send_item(OP_CMD, 8'hFF, 6'd63, 1'b1);
		tick_until_idle();
		send_item(OP_DATA, 8'h00, 6'd0, 1'b0);
		tick_until_idle();
		send_item(OP_DATA, 8'hFF, 6'd0, 1'b0);
		tick_until_idle();
		send_item(OP_MOVE, 8'hFF, 6'd0, 1'b0);
		tick_until_idle();
		send_item(OP_MOVE, 8'h00, 6'd39, 1'b1);
		tick_until_idle();
		send_item(OP_MOVE, 8'h00, 6'd40, 1'b0);
		tick_until_idle();
		send_item(OP_MOVE, 8'h00, 6'd63, 1'b1);
		tick_until_idle();
		send_item(OP_DATA, 8'h5A, 6'd0, 1'b0);
		tick_n(2);
		send_item(OP_CMD, 8'h77, 6'd0, 1'b0);
		send_item(OP_MOVE, 8'h00, 6'd5, 1'b1);
		send_item(OP_DATA, 8'hA5, 6'd0, 1'b0);
		tick_until_idle();
		tick();

		// Long enable times; the high time is rewritten while a pulse runs.
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		wait_for_results();
		write_reg(REG_ENABLE_HIGH, 16'd40);
		write_reg(REG_ENABLE_LOW, 16'd40);
		send_item(OP_CMD, 8'hC3, 6'd0, 1'b0);
		tick_n(10);
		wait_for_results();
		write_reg(REG_ENABLE_HIGH, 16'd2);
		tick_n(40);
		wait_for_results();
		write_reg(REG_ENABLE_LOW, 16'd1);
		tick_until_idle();
		wait_for_results();
		write_reg(REG_POWER_UP, 16'hFFFF);
		write_reg(REG_INIT_LONG, 16'hFFFF);
		write_reg(REG_INIT_SHORT, 16'hFFFF);
		write_reg(REG_CLEAR_WAIT, 16'hFFFF);
		write_reg(REG_CLEAR_WAIT, 16'd1);
		write_reg(REG_INIT_LONG, 16'd1);

		for (p = 0; p < 6; p++) begin
			tx_gaps = (p != 3);
			rx_gaps = (p != 3);
			wait_for_results();
			write_reg(REG_ENABLE_HIGH, short_ticks());
			write_reg(REG_ENABLE_LOW, short_ticks());
			if ($urandom_range(0, 1) == 1)
				write_reg(3'($urandom_range(REG_POWER_UP, REG_UNUSED_HI)), 16'($urandom));
			if (p == 1) begin
				hold_len = HOLD_LONG;
				hold_req = 1'b1;
			end
			random_phase(120);
		end

		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		wait_for_results();
		write_reg(REG_ENABLE_HIGH, short_ticks());
		write_reg(REG_ENABLE_LOW, short_ticks());
		random_phase(100);

		wait_for_results();
		repeat (8) @(posedge clk);
		$display("Sent %0d items, checked %0d results, %0d requests taken by the sequencer.",
			sent, checked_count, taken_count);
		$display("Covered init, rejected requests, zero and 65535 tick timings and long stalls.");
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
